// ===== hw/rtl/fhr_pkg.sv =====
// Shared constants and the item type for the Feistel hash-to-range unit.
// No dependencies.
package fhr_pkg;

    localparam logic [63:0] GOLDEN64    = 64'h9e3779b97f4a7c15;
    localparam logic [31:0] GOLDEN32    = 32'h9e3779b9;
    localparam int          SHIFT_A     = 13;
    localparam int          SHIFT_B     = 27;
    localparam int          SHIFT_C     = 31;
    localparam int          DATA_W      = 64;
    localparam int          FIFO_DEPTH  = 8;
    localparam int          FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int          FRONT_STG   = 3;
    localparam int          BUSY_LEVEL  = FIFO_DEPTH - FRONT_STG;

    // Hashed transaction handed from the front part to the divider
    typedef struct packed {
        logic [DATA_W-1:0] mixed;
        logic [DATA_W-1:0] low;
        logic [DATA_W-1:0] span;
        logic              empty;
    } t_item;

endpackage

// ===== hw/rtl/fhr_front.sv =====
// Front part: accepts transactions, classifies empty ranges, runs the
// Feistel rounds and the xorshift mix. Depends on fhr_pkg.
module fhr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [fhr_pkg::DATA_W-1:0]  i_seed_value,
    input  logic [fhr_pkg::DATA_W-1:0]  i_range_low,
    input  logic [fhr_pkg::DATA_W-1:0]  i_range_high,
    output logic                        o_push,
    output fhr_pkg::t_item              o_item
);

    logic                       r_v0, r_v1, r_v2;
    logic [31:0]                r_hi0, r_lo0, r_hi1, r_lo1;
    logic [fhr_pkg::DATA_W-1:0] r_low0, r_span0, r_low1, r_span1;
    logic                       r_emp0, r_emp1;
    fhr_pkg::t_item             r_item;
    logic [fhr_pkg::DATA_W-1:0] n_seed_x;
    logic [31:0]                n_prod0, n_prod1, n_hi1, n_lo2;
    logic [fhr_pkg::DATA_W-1:0] n_z;

    // Whiten the seed and split it
    assign n_seed_x = i_seed_value ^ fhr_pkg::GOLDEN64;
    // First round: high half takes the low half's product
    assign n_prod0  = r_lo0 * fhr_pkg::GOLDEN32;
    assign n_hi1    = r_hi0 ^ n_prod0;
    // Second round, then rejoin and mix
    assign n_prod1  = r_hi1 * fhr_pkg::GOLDEN32;
    assign n_lo2    = r_lo1 ^ n_prod1;
    always_comb begin
        logic [fhr_pkg::DATA_W-1:0] z;
        z   = {r_hi1, n_lo2};
        n_z = z ^ (z >> fhr_pkg::SHIFT_A) ^ (z >> fhr_pkg::SHIFT_B)
                ^ (z >> fhr_pkg::SHIFT_C);
    end

    // Advance the valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_accept;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // Hold payload per stage
    always_ff @(posedge i_clk) begin
        r_hi0         <= n_seed_x[63:32];
        r_lo0         <= n_seed_x[31:0];
        r_low0        <= i_range_low;
        r_span0       <= i_range_high - i_range_low;
        r_emp0        <= !($signed(i_range_low) < $signed(i_range_high));
        r_hi1         <= n_hi1;
        r_lo1         <= r_lo0;
        r_low1        <= r_low0;
        r_span1       <= r_span0;
        r_emp1        <= r_emp0;
        r_item.mixed  <= n_z;
        r_item.low    <= r_low1;
        r_item.span   <= r_span1;
        r_item.empty  <= r_emp1;
    end

    assign o_push = r_v2;
    assign o_item = r_item;

endmodule

// ===== hw/rtl/fhr_fifo.sv =====
// Short queue between the hash front part and the divider back part.
// Depends on fhr_pkg.
module fhr_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  fhr_pkg::t_item                i_item,
    input  logic                          i_pop,
    output logic                          o_not_empty,
    output fhr_pkg::t_item                o_item,
    output logic [fhr_pkg::FIFO_AW:0]     o_count
);

    fhr_pkg::t_item               r_mem [fhr_pkg::FIFO_DEPTH];
    logic [fhr_pkg::FIFO_AW-1:0]  r_wr, r_rd;
    logic [fhr_pkg::FIFO_AW:0]    r_count;
    logic                         n_do_pop;

    assign n_do_pop = i_pop && (r_count != '0);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push)   r_wr <= r_wr + 1'b1;
            if (n_do_pop) r_rd <= r_rd + 1'b1;
            r_count <= r_count + (fhr_pkg::FIFO_AW+1)'(i_push)
                               - (fhr_pkg::FIFO_AW+1)'(n_do_pop);
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd];
    assign o_count     = r_count;

endmodule

// ===== hw/rtl/fhr_back.sv =====
// Back part: one-bit-per-stage restoring remainder pipeline, then the
// offset add and the result register. Depends on fhr_pkg.
module fhr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  fhr_pkg::t_item              i_item,
    output logic                        o_valid,
    output logic [fhr_pkg::DATA_W-1:0]  o_result
);

    localparam int NS = fhr_pkg::DATA_W;

    logic                       r_vld  [NS+1];
    logic [fhr_pkg::DATA_W-1:0] r_rem  [NS+1];
    logic [fhr_pkg::DATA_W-1:0] r_num  [NS+1];
    fhr_pkg::t_item             r_meta [NS+1];
    logic [fhr_pkg::DATA_W-1:0] n_rem  [NS];
    logic                       r_out_v;
    logic [fhr_pkg::DATA_W-1:0] r_out;

    // One quotient bit per stage
    always_comb begin
        logic [fhr_pkg::DATA_W:0] sh;
        logic [fhr_pkg::DATA_W:0] df;
        for (int k = 0; k < NS; k++) begin
            sh = {r_rem[k], r_num[k][fhr_pkg::DATA_W-1]};
            df = sh - {1'b0, r_meta[k].span};
            n_rem[k] = df[fhr_pkg::DATA_W] ? sh[fhr_pkg::DATA_W-1:0]
                                            : df[fhr_pkg::DATA_W-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) r_vld[k] <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < NS; k++) r_vld[k+1] <= r_vld[k];
            r_out_v <= r_vld[NS];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_num[0]  <= i_item.mixed;
        r_meta[0] <= i_item;
        for (int k = 0; k < NS; k++) begin
            r_rem[k+1]  <= n_rem[k];
            r_num[k+1]  <= r_num[k] << 1;
            r_meta[k+1] <= r_meta[k];
        end
        r_out <= r_meta[NS].empty ? r_meta[NS].low : r_rem[NS] + r_meta[NS].low;
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

// ===== hw/rtl/feistel_hash_to_range_unit.sv =====
// Feistel hash-to-range unit: front hash pipeline, queue, divider back part.
// Throughput: one transaction per cycle; set by the 64-stage remainder pipeline.
// busy rises only if the queue nears full, which never happens as the back
// part drains one entry every cycle; results cannot be held off.
// Reset (synchronous, active low) clears all valid bits and queue pointers.
module feistel_hash_to_range_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [fhr_pkg::DATA_W-1:0]  i_seed_value,
    input  logic [fhr_pkg::DATA_W-1:0]  i_range_low,
    input  logic [fhr_pkg::DATA_W-1:0]  i_range_high,
    output logic                        o_valid,
    output logic [fhr_pkg::DATA_W-1:0]  o_random_result
);

    logic                       accept;
    logic                       push;
    logic                       not_empty;
    fhr_pkg::t_item             front_item;
    fhr_pkg::t_item             head_item;
    logic [fhr_pkg::FIFO_AW:0]  count;

    assign busy   = (count >= (fhr_pkg::FIFO_AW+1)'(fhr_pkg::BUSY_LEVEL));
    assign accept = start && !busy;

    fhr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_seed_value (i_seed_value),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_push       (push),
        .o_item       (front_item)
    );

    fhr_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (front_item),
        .i_pop       (1'b1),
        .o_not_empty (not_empty),
        .o_item      (head_item),
        .o_count     (count)
    );

    fhr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (not_empty),
        .i_item   (head_item),
        .o_valid  (o_valid),
        .o_result (o_random_result)
    );

`ifndef SYNTH
    // Back part drains every cycle, so the queue never fills up
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("queue backed up");
    // A pushed entry is visible at the head next cycle
    a_push_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> not_empty)
        else $error("pushed entry lost");
    // Queue holds at most one entry at any time
    a_shallow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= (fhr_pkg::FIFO_AW+1)'(1))
        else $error("queue deeper than expected");
`endif

endmodule

// ===== bench/fhr_checker.sv =====
// Checker for the Feistel hash-to-range unit: predicts each result and compares.
// Depends on fhr_pkg for the data width and hash constants.
`timescale 1ns / 1ps
module fhr_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [fhr_pkg::DATA_W-1:0]  i_seed_value,
    input  logic [fhr_pkg::DATA_W-1:0]  i_range_low,
    input  logic [fhr_pkg::DATA_W-1:0]  i_range_high,
    input  logic                        i_valid,
    input  logic [fhr_pkg::DATA_W-1:0]  i_random_result,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int EXP_DEPTH = 256;

    logic [fhr_pkg::DATA_W-1:0] exp_ring [EXP_DEPTH];
    logic [7:0]                 wr_ptr;
    logic [7:0]                 rd_ptr;
    int                         exp_count;

    // Hash the seed and reduce it into [low, high); an empty range yields low
    function automatic logic [fhr_pkg::DATA_W-1:0] hash_to_range(
        input logic [fhr_pkg::DATA_W-1:0] seed,
        input logic [fhr_pkg::DATA_W-1:0] low,
        input logic [fhr_pkg::DATA_W-1:0] high
    );
        logic [fhr_pkg::DATA_W-1:0] s;
        logic [fhr_pkg::DATA_W-1:0] z;
        logic [31:0]                half_lo;
        logic [31:0]                half_hi;
        if ($signed(low) >= $signed(high)) begin
            return low;
        end
        s = seed ^ fhr_pkg::GOLDEN64;
        half_lo = s[31:0];
        half_hi = s[63:32];
        half_hi = half_hi ^ (half_lo * fhr_pkg::GOLDEN32);
        half_lo = half_lo ^ (half_hi * fhr_pkg::GOLDEN32);
        z = {half_hi, half_lo};
        z = z ^ (z >> fhr_pkg::SHIFT_A) ^ (z >> fhr_pkg::SHIFT_B)
              ^ (z >> fhr_pkg::SHIFT_C);
        return (z % (high - low)) + low;
    endfunction

    assign o_pending = exp_count;

    // Predict on each accepted transaction, compare on each strobe
    always @(posedge i_clk) begin
        logic do_push;
        logic do_pop;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            wr_ptr       <= '0;
            rd_ptr       <= '0;
            exp_count    <= 0;
        end else begin
            do_push = i_start && !i_busy;
            do_pop  = 1'b0;
            if (do_push) begin
                exp_ring[wr_ptr] <= hash_to_range(i_seed_value, i_range_low,
                                                  i_range_high);
                wr_ptr <= wr_ptr + 8'd1;
            end
            if (i_valid) begin
                if (exp_count == 0) begin
                    $error("unexpected result %h", i_random_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    do_pop = 1'b1;
                    rd_ptr <= rd_ptr + 8'd1;
                    if (exp_ring[rd_ptr] !== i_random_result) begin
                        $error("random_result expected %h actual %h",
                               exp_ring[rd_ptr], i_random_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            exp_count <= exp_count + int'(do_push) - int'(do_pop);
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the testbench: clock, reset, stimulus and verdict.
// Depends on fhr_pkg, feistel_hash_to_range_unit and fhr_checker.
`timescale 1ns / 1ps
module tb_top;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [fhr_pkg::DATA_W-1:0] seed_value = '0;
    logic [fhr_pkg::DATA_W-1:0] range_low = '0;
    logic [fhr_pkg::DATA_W-1:0] range_high = '0;
    logic                       valid;
    logic [fhr_pkg::DATA_W-1:0] random_result;
    int                         fail_count;
    int                         pending;

    localparam logic [fhr_pkg::DATA_W-1:0] MIN64 = 64'h8000000000000000;
    localparam logic [fhr_pkg::DATA_W-1:0] MAX64 = 64'h7fffffffffffffff;
    localparam int NUM_RANDOM = 1650;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    feistel_hash_to_range_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy),
        .i_seed_value(seed_value), .i_range_low(range_low), .i_range_high(range_high),
        .o_valid(valid), .o_random_result(random_result)
    );

    fhr_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_seed_value(seed_value), .i_range_low(range_low), .i_range_high(range_high),
        .i_valid(valid), .i_random_result(random_result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [fhr_pkg::DATA_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Drive one transaction and hold it until accepted
    task automatic send_hash(input logic [fhr_pkg::DATA_W-1:0] seed,
                             input logic [fhr_pkg::DATA_W-1:0] low,
                             input logic [fhr_pkg::DATA_W-1:0] high,
                             input bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(3) == 0) begin
            start <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        seed_value <= seed;
        range_low  <= low;
        range_high <= high;
        do @(posedge clk); while (busy);
    endtask

    // Pick a bound pair: mostly valid ranges of assorted spans, some empty ones
    task automatic pick_bounds(output logic [fhr_pkg::DATA_W-1:0] low,
                               output logic [fhr_pkg::DATA_W-1:0] high);
        logic [fhr_pkg::DATA_W-1:0] span;
        case ($urandom_range(5))
            0: span = 64'($urandom_range(1, 16));
            1: span = 64'($urandom());
            2: span = rand64() >> $urandom_range(63);
            3: span = rand64();
            default: span = '0;
        endcase
        low = rand64();
        if ($urandom_range(3) == 0) low = low >> $urandom_range(63);
        high = ($urandom_range(7) == 0) ? rand64() : low + span;
    endtask

    initial begin
        logic [fhr_pkg::DATA_W-1:0] lo;
        logic [fhr_pkg::DATA_W-1:0] hi;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, empty and inverted ranges, full-width span
        send_hash('0, '0, 64'd1, 1'b0);
        send_hash('1, MIN64, MAX64, 1'b0);
        send_hash(MAX64, MIN64, MAX64, 1'b0);
        send_hash(MIN64, 64'd5, 64'd5, 1'b0);
        send_hash(64'h1234, MAX64, MIN64, 1'b0);
        send_hash(64'h5678, 64'd10, -64'sd10, 1'b0);
        send_hash(fhr_pkg::GOLDEN64, -64'sd3, 64'd4, 1'b0);
        send_hash('1, MAX64 - 64'd1, MAX64, 1'b0);
        send_hash('0, MIN64, MIN64 + 64'd1, 1'b0);
        send_hash(64'hdeadbeefcafef00d, '0, MAX64, 1'b0);
        send_hash(64'h0123456789abcdef, -64'sd1000, 64'd1000, 1'b0);
        send_hash('1, '1, '0, 1'b0);
        send_hash(MIN64, 64'd1, 64'h100000000, 1'b0);

        // Random, with gaps, then a gap-free tail
        for (int n = 0; n < NUM_RANDOM; n++) begin
            pick_bounds(lo, hi);
            send_hash(rand64(), lo, hi, n < NUM_RANDOM - 200);
        end
        start <= 1'b0;

        wait (pending == 0);
        repeat (80) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
